[design/sfc_pkg.sv]
`timescale 1ns / 1ps

package sfc_pkg;

    // Field widths of one received byte and one result.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FLEN_W   = 25;
    localparam int unsigned LEN_W    = 24;
    localparam int unsigned CFG_W    = 24;

    // Packed result width and its byte-aligned bus width.
    localparam int unsigned RES_W      = STATUS_W + FLEN_W + BYTE_W;
    localparam int unsigned RES_BUS_W  = ((RES_W + 7) / 8) * 8;

    // Header and trailer bytes around the payload: start, count, four length bytes, checksum.
    localparam logic [FLEN_W-1:0] FRAME_OVERHEAD = FLEN_W'(7);

    // Last index of the four little-endian length bytes.
    localparam logic [1:0] LEN_LAST_IDX = 2'd3;

    // Configuration register indexes.
    typedef enum logic {
        CFG_START_BYTE = 1'b0,
        CFG_MAX_LEN    = 1'b1
    } t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_SUM   = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_COUNT   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [LEN_W-1:0]  max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] command_count;
        logic [FLEN_W-1:0] frame_length;
        t_status           status;
    } t_result;

endpackage

[design/sfc_cfg.sv]
`timescale 1ns / 1ps

module sfc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [sfc_pkg::CFG_W-1:0]    i_cfg_data,
    output sfc_pkg::t_cfg                o_cfg
);
    import sfc_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_max_len    <= LEN_W'(65536);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_BYTE: r_start_byte <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[LEN_W-1:0];
                default:        r_max_len    <= r_max_len;
            endcase
        end
    end

    assign o_cfg.start_byte = r_start_byte;
    assign o_cfg.max_len    = r_max_len;

endmodule

[design/sfc_parser.sv]
`timescale 1ns / 1ps

module sfc_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [sfc_pkg::BYTE_W-1:0]   i_byte,
    input  sfc_pkg::t_cfg                i_cfg,
    output logic                         o_res_valid,
    output sfc_pkg::t_result             o_res
);
    import sfc_pkg::*;

    t_phase            r_phase,  n_phase;
    logic [1:0]        r_hdr_idx, n_hdr_idx;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic [BYTE_W-1:0] r_sum,    n_sum;
    logic [BYTE_W-1:0] r_count,  n_count;

    logic [BYTE_W-1:0] sum_plus;
    logic              too_long;

    assign sum_plus = r_sum + i_byte;
    // At the fourth length byte the incoming byte is the top byte of a 32-bit length.
    assign too_long = (i_byte != '0) || (r_len > i_cfg.max_len);

    // Next state.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_len     = r_len;
        n_remain  = r_remain;
        n_sum     = r_sum;
        n_count   = r_count;
        unique case (r_phase)
            PH_COUNT: begin
                n_count   = i_byte;
                n_sum     = i_byte;
                n_hdr_idx = '0;
                n_len     = '0;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_sum = sum_plus;
                unique case (r_hdr_idx)
                    2'd0:    n_len[7:0]   = i_byte;
                    2'd1:    n_len[15:8]  = i_byte;
                    2'd2:    n_len[23:16] = i_byte;
                    default: n_len        = r_len;
                endcase
                if (r_hdr_idx != LEN_LAST_IDX) begin
                    n_hdr_idx = r_hdr_idx + 2'd1;
                end else begin
                    n_hdr_idx = '0;
                    n_remain  = r_len;
                    if (too_long) begin
                        n_phase = PH_HUNT;
                    end else if (r_len == '0) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_sum    = sum_plus;
                n_remain = r_remain - LEN_W'(1);
                if (r_remain == LEN_W'(1)) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
            end
            default: begin
                // Hunting, and any unused phase code behaves the same.
                n_phase = (i_byte == i_cfg.start_byte) ? PH_COUNT : PH_HUNT;
            end
        endcase
    end

    // Result of the current byte.
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.status         = ST_OK;
        o_res.frame_length   = '0;
        o_res.command_count  = '0;
        unique case (r_phase)
            PH_COUNT, PH_PAYLOAD: begin
                o_res_valid = 1'b0;
            end
            PH_LEN: begin
                if (r_hdr_idx == LEN_LAST_IDX && too_long) begin
                    o_res_valid         = 1'b1;
                    o_res.status        = ST_TOO_LONG;
                    o_res.command_count = r_count;
                end
            end
            PH_CHECK: begin
                o_res_valid         = 1'b1;
                o_res.status        = (sum_plus == '0) ? ST_OK : ST_BAD_SUM;
                o_res.frame_length  = FLEN_W'(r_len) + FRAME_OVERHEAD;
                o_res.command_count = r_count;
            end
            default: begin
                if (i_byte != i_cfg.start_byte) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BAD_START;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hdr_idx <= '0;
            r_len     <= '0;
            r_remain  <= '0;
            r_sum     <= '0;
            r_count   <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_len     <= n_len;
            r_remain  <= n_remain;
            r_sum     <= n_sum;
            r_count   <= n_count;
        end
    end

endmodule

[design/serial_frame_checksum_parser.sv]
`timescale 1ns / 1ps

// The byte register feeds the parser, which feeds the result register on the master side.
// Throughput: one byte per cycle while the result register has room for any result the byte yields.
// The byte register keeps moving while a result waits, as long as the byte it holds yields no result.
// Reset (synchronous, active low) empties both registers, returns the parser to hunting for a
// start byte and loads start_byte = 0 and max_payload_len = 65536.
module serial_frame_checksum_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side: tdata holds rx_byte [7:0].
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sfc_pkg::BYTE_W-1:0]       s_axis_tdata,
    // Master side: tdata holds status [1:0], frame_length [26:2], command_count [34:27],
    // and zero padding [39:35].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sfc_pkg::RES_BUS_W-1:0]    m_axis_tdata,
    // Configuration write port: index 0 is start_byte, index 1 is max_payload_len.
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [sfc_pkg::CFG_W-1:0]        i_cfg_data
);
    import sfc_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              res_valid;
    t_result           res;
    logic              advance;

    sfc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The byte held in the input register is consumed when its result, if any, has room:
    // the result register is empty, is being drained this cycle, or the byte yields nothing.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready || !res_valid);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register: loaded when the parser produces a result, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = RES_BUS_W'(r_out);

endmodule

[design/sfc_checker.sv]
`timescale 1ns / 1ps

module sfc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [sfc_pkg::RES_BUS_W-1:0]    m_axis_tdata
);
    import sfc_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [FLEN_W-1:0]   flen;
    logic [BYTE_W-1:0]   cnt;

    assign status = m_axis_tdata[STATUS_W-1:0];
    assign flen   = m_axis_tdata[STATUS_W +: FLEN_W];
    assign cnt    = m_axis_tdata[STATUS_W+FLEN_W +: BYTE_W];

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present after reset");

    // A result that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // A bad start carries neither a length nor a command count.
    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_BAD_START |-> flen == '0 && cnt == '0)
        else $error("bad start result carries frame data");

    // A too-long frame reports no length; a finished frame counts at least its overhead.
    a_len_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (status == ST_TOO_LONG && flen == '0) ||
                          ((status == ST_OK || status == ST_BAD_SUM) && flen >= FRAME_OVERHEAD) ||
                          status == ST_BAD_START)
        else $error("frame length inconsistent with status");

    // Padding bits above the packed result stay zero.
    a_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[RES_BUS_W-1:RES_W] == '0)
        else $error("padding bits set in result beat");

endmodule

bind serial_frame_checksum_parser sfc_checker u_sfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_serial_frame_checksum_parser.sv]
`timescale 1ns / 1ps

module tb_serial_frame_checksum_parser;
    import sfc_pkg::*;

    // Cycles without any beat on either side before the run is declared hung. The long
    // receiver hold-off lasts HOLD_CYCLES, so the limit sits well above it.
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned HOLD_AFTER     = 4;
    localparam int unsigned SETTLE_CYCLES  = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // rx_byte [7:0]
    logic [BYTE_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // status [1:0], frame_length [26:2], command_count [34:27], zero padding [39:35]
    logic [RES_BUS_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = CFG_START_BYTE;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    serial_frame_checksum_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes waiting to be sent, and the frame reports the parser is expected to produce.
    logic [BYTE_W-1:0] rx_stream[$];
    t_result           frame_reports[$];
    int unsigned       bytes_queued = 0;
    int unsigned       report_count = 0;
    int unsigned       mismatches = 0;

    // Our copy of the configuration registers, updated only while the block is idle.
    logic [BYTE_W-1:0] start_cfg = 8'h00;
    logic [LEN_W-1:0]  max_cfg = 24'd65536;

    // Shadow parser state.
    t_phase            ph = PH_HUNT;
    logic [1:0]        len_idx = '0;
    logic [31:0]       len_word = '0;
    logic [LEN_W-1:0]  left = '0;
    logic [7:0]        sum8 = '0;
    logic [7:0]        cnt8 = '0;

    // Advances the shadow parser by one accepted byte and queues any report it causes.
    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        t_result    r;
        logic [7:0] total;
        r = '0;
        case (ph)
            PH_COUNT: begin
                cnt8 = b;
                sum8 = b;
                len_idx = '0;
                len_word = '0;
                ph = PH_LEN;
            end
            PH_LEN: begin
                sum8 = sum8 + b;
                len_word = len_word | (32'(b) << (8 * len_idx));
                if (len_idx != LEN_LAST_IDX) begin
                    len_idx = len_idx + 2'd1;
                end else begin
                    len_idx = '0;
                    // The full 32-bit length is compared, so any nonzero top byte is too long.
                    if (len_word > 32'(max_cfg)) begin
                        ph = PH_HUNT;
                        r.status = ST_TOO_LONG;
                        r.command_count = cnt8;
                        frame_reports.push_back(r);
                    end else begin
                        left = len_word[LEN_W-1:0];
                        if (left == '0) begin
                            ph = PH_CHECK;
                        end else begin
                            ph = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                sum8 = sum8 + b;
                left = left - 1'b1;
                if (left == '0) begin
                    ph = PH_CHECK;
                end
            end
            PH_CHECK: begin
                total = sum8 + b;
                if (total == 8'h00) begin
                    r.status = ST_OK;
                end else begin
                    r.status = ST_BAD_SUM;
                end
                r.frame_length = FLEN_W'(len_word[LEN_W-1:0]) + FRAME_OVERHEAD;
                r.command_count = cnt8;
                ph = PH_HUNT;
                frame_reports.push_back(r);
            end
            default: begin
                if (b == start_cfg) begin
                    ph = PH_COUNT;
                end else begin
                    ph = PH_HUNT;
                    r.status = ST_BAD_START;
                    frame_reports.push_back(r);
                end
            end
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps. A beat that is not taken
    // stays on the bus unchanged until the parser accepts it.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_stream.size() > 0) begin
                    s_axis_tdata <= rx_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A quarter of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Compares one report beat against the oldest expectation, field by field.
    task automatic check_report(input t_result got);
        t_result want;
        if (frame_reports.size() == 0) begin
            $error("report with none expected: status %0d frame_length %0d command_count %0d",
                   got.status, got.frame_length, got.command_count);
            mismatches++;
        end else begin
            want = frame_reports.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, got %0d", want.frame_length,
                       got.frame_length);
                mismatches++;
            end
            if (got.command_count !== want.command_count) begin
                $error("command_count: expected %0d, got %0d", want.command_count,
                       got.command_count);
                mismatches++;
            end
        end
    endtask

    // Receiver: tready follows a rotating 8-bit pattern that is redrawn at random and is
    // sometimes all ones, so that long stretches run without stalls. Once, after the first
    // few reports while plenty of bytes are still queued, it holds off for a long stretch
    // so that the result register and the byte register fill and the parser pushes back
    // on its input.
    logic [7:0]  ready_pat = 8'hFF;
    int unsigned pat_age = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_report(t_result'(m_axis_tdata[RES_W-1:0]));
                report_count++;
            end
            if (!hold_done && report_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (pat_age == 0) begin
                    pat_age = 64;
                    ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    if (ready_pat == 8'h00) begin
                        ready_pat = 8'h01;
                    end
                end
                pat_age--;
                m_axis_tready <= ready_pat[0];
                ready_pat = {ready_pat[0], ready_pat[7:1]};
            end
        end
    end

    // Watchdog: any beat on either side restarts the count.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endtask

    // Register writes happen only while the parser is idle, so our copy is updated at once.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_START_BYTE) begin
            start_cfg = value[BYTE_W-1:0];
        end else begin
            max_cfg = value[LEN_W-1:0];
        end
    endtask

    // Builds one frame with the current start byte. A length above the maximum sends only
    // the header, since the parser gives up there. The last 'drop' bytes are cut off to
    // make a broken frame.
    task automatic push_frame(input logic [7:0] cnt, input logic [31:0] len, input bit sum_ok,
                              input int unsigned drop);
        logic [7:0] body[$];
        logic [7:0] sum;
        logic [7:0] ck;
        body.push_back(start_cfg);
        body.push_back(cnt);
        for (int i = 0; i < 4; i++) begin
            body.push_back(len[8*i +: 8]);
        end
        if (len <= 32'(max_cfg)) begin
            for (int unsigned i = 0; i < len; i++) begin
                body.push_back(8'($urandom));
            end
            sum = '0;
            for (int i = 1; i < body.size(); i++) begin
                sum = sum + body[i];
            end
            ck = ~sum + 8'd1;
            if (!sum_ok) begin
                ck = ck + 8'($urandom_range(1, 255));
            end
            body.push_back(ck);
        end
        repeat (drop) begin
            if (body.size() > 0) begin
                void'(body.pop_back());
            end
        end
        foreach (body[i]) begin
            queue_byte(body[i]);
        end
    endtask

    // Random stream: mostly well-formed frames with random content, plus too-long headers,
    // noise bytes while hunting and, where the maximum is small, frames cut short. Noise
    // never equals the start byte, and cut frames keep their header, so a large maximum
    // cannot make the parser swallow the rest of the run as one endless payload.
    task automatic random_traffic(input int unsigned n_bytes, input bit allow_broken);
        int unsigned goal;
        int unsigned pick;
        int unsigned k;
        logic [31:0] len;
        logic [7:0]  b;
        goal = bytes_queued + n_bytes;
        while (bytes_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    b = 8'($urandom);
                    if (b == start_cfg) begin
                        b = b ^ 8'h01;
                    end
                    queue_byte(b);
                end
            end else if (pick < 22) begin
                if ($urandom_range(0, 1) == 0) begin
                    len = 32'(max_cfg) + 32'd1 + 32'($urandom_range(0, 3));
                end else begin
                    len = 32'($urandom) | 32'h0100_0000;
                end
                push_frame(8'($urandom), len, 1'b1, 0);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    len = (max_cfg <= 40) ? 32'(max_cfg) : 32'($urandom_range(13, 40));
                end else begin
                    len = 32'($urandom_range(0, 12));
                end
                if (len > 32'(max_cfg)) begin
                    len = 32'(max_cfg);
                end
                if (allow_broken && pick < 32) begin
                    push_frame(8'($urandom), len, 1'b1, $urandom_range(1, len + 1));
                end else begin
                    push_frame(8'($urandom), len, $urandom_range(0, 4) != 0, 0);
                end
            end
        end
    endtask

    // Waits until every byte has been accepted and every report has arrived, then lets the
    // pipeline settle, since a partial frame may still be moving through it.
    task automatic drain();
        while (rx_stream.size() != 0 || s_axis_tvalid || frame_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: start byte 0x00, maximum 65536. A bad start byte, empty
        // frames with good and bad checksums, a length one above the maximum and a
        // short good frame.
        queue_byte(8'hFF);
        push_frame(8'h00, 32'd0, 1'b1, 0);
        push_frame(8'hFF, 32'd0, 1'b0, 0);
        push_frame(8'h12, 32'd65537, 1'b1, 0);
        push_frame(8'h34, 32'd2, 1'b1, 0);
        random_traffic(50, 1'b0);
        drain();

        // Start byte 0xFF with a maximum of zero: only empty frames pass.
        write_reg(CFG_START_BYTE, 24'h0000FF);
        write_reg(CFG_MAX_LEN, 24'd0);
        push_frame(8'h55, 32'd0, 1'b1, 0);
        push_frame(8'hAA, 32'd1, 1'b1, 0);
        queue_byte(8'h00);
        random_traffic(50, 1'b0);
        drain();

        // Largest maximum, with one long frame so that the second length byte is nonzero.
        write_reg(CFG_START_BYTE, 24'($urandom_range(1, 254)));
        write_reg(CFG_MAX_LEN, 24'hFFFFFF);
        push_frame(8'h81, 32'd260, 1'b1, 0);
        random_traffic(50, 1'b0);
        drain();

        // Small maxima, where cut frames and resynchronization are safe to exercise.
        write_reg(CFG_START_BYTE, 24'($urandom_range(0, 255)));
        write_reg(CFG_MAX_LEN, 24'd24);
        random_traffic(80, 1'b1);
        drain();

        write_reg(CFG_MAX_LEN, 24'd5);
        write_reg(CFG_START_BYTE, 24'($urandom_range(0, 255)));
        random_traffic(80, 1'b1);
        drain();

        write_reg(CFG_START_BYTE, 24'h000000);
        write_reg(CFG_MAX_LEN, 24'd255);
        random_traffic(80, 1'b1);
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
